// ----- rtl/core/mrse_pkg.sv -----
package mrse_pkg;

    // MIDI status codes that steer the expansion.
    localparam logic [7:0] ST_REALTIME_MIN = 8'hF8;
    localparam logic [7:0] ST_SYSEX_START  = 8'hF0;
    localparam logic [7:0] ST_TUNE_REQUEST = 8'hF6;
    localparam logic [7:0] ST_SYSEX_END    = 8'hF7;
    localparam logic [7:0] ST_UNDEF_F4     = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5     = 8'hF5;
    localparam logic [7:0] ST_ONE_DATA_MIN = 8'hC0;
    localparam logic [7:0] ST_ONE_DATA_END = 8'hE0;
    localparam logic [7:0] ST_SONG_POS     = 8'hF2;
    localparam logic [7:0] ST_NONE         = 8'h00;

    // Depth of the job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Up to three result bytes are produced for one input item.
    localparam int MAX_BYTES = 3;

    typedef logic [1:0] t_count;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        t_count                    count;
        logic                      busy;
    } t_job;

endpackage

// ----- rtl/core/mrse_front.sv -----
module mrse_front
    import mrse_pkg::*;
#(
    parameter int NUM_SOURCES = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_source_port,
    input  logic [7:0] i_raw_byte,
    output logic       o_job_push,
    output t_job       o_job
);

    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    // Per-port expansion state.
    logic [7:0] r_rs  [NUM_SOURCES];
    logic [7:0] r_hs  [NUM_SOURCES];
    logic [6:0] r_hfd [NUM_SOURCES];
    logic       r_aw  [NUM_SOURCES];
    logic       r_mb  [NUM_SOURCES];

    logic             w_in_range;
    logic [IDX_W-1:0] w_idx;
    logic [7:0]       w_rs;
    logic [7:0]       w_hs;
    logic [6:0]       w_hfd;
    logic             w_aw;
    logic             w_mb;
    logic [7:0]       n_rs;
    logic [7:0]       n_hs;
    logic [6:0]       n_hfd;
    logic             n_aw;
    logic             n_mb;
    t_job             w_job;

    // Select the state of the addressed port.
    assign w_in_range = (32'(i_source_port) < NUM_SOURCES);
    assign w_idx      = w_in_range ? IDX_W'(i_source_port) : '0;
    assign w_rs       = r_rs[w_idx];
    assign w_hs       = r_hs[w_idx];
    assign w_hfd      = r_hfd[w_idx];
    assign w_aw       = r_aw[w_idx];
    assign w_mb       = r_mb[w_idx];

    // Classify the byte and build the job of result bytes.
    always_comb begin
        n_rs  = w_rs;
        n_hs  = w_hs;
        n_hfd = w_hfd;
        n_aw  = w_aw;
        n_mb  = w_mb;
        w_job = '0;
        if (i_raw_byte[7]) begin
            priority if (i_raw_byte >= ST_REALTIME_MIN) begin
                w_job.bytes[0] = i_raw_byte;
                w_job.count    = 2'd1;
                w_job.busy     = w_mb;
            end else begin
                n_aw = 1'b0;
                n_rs = i_raw_byte;
                priority if (i_raw_byte < ST_SYSEX_START) begin
                    // Channel status is held until its data arrives.
                end else if (i_raw_byte == ST_SYSEX_START) begin
                    n_mb           = 1'b1;
                    w_job.bytes[0] = i_raw_byte;
                    w_job.count    = 2'd1;
                    w_job.busy     = 1'b1;
                end else if (i_raw_byte == ST_TUNE_REQUEST || i_raw_byte == ST_SYSEX_END) begin
                    n_rs           = ST_NONE;
                    n_mb           = 1'b0;
                    w_job.bytes[0] = i_raw_byte;
                    w_job.count    = 2'd1;
                    w_job.busy     = 1'b0;
                end else if (i_raw_byte == ST_UNDEF_F4 || i_raw_byte == ST_UNDEF_F5) begin
                    n_rs = ST_NONE;
                end else begin
                    // Other system common status waits for its data.
                end
            end
        end else begin
            priority if (w_aw) begin
                n_aw           = 1'b0;
                n_mb           = 1'b0;
                w_job.bytes[0] = w_hs;
                w_job.bytes[1] = {1'b0, w_hfd};
                w_job.bytes[2] = i_raw_byte;
                w_job.count    = 2'd3;
                w_job.busy     = 1'b0;
            end else if (w_rs == ST_NONE) begin
                // Orphan data is dropped.
            end else if (w_rs == ST_SYSEX_START) begin
                w_job.bytes[0] = i_raw_byte;
                w_job.count    = 2'd1;
                w_job.busy     = w_mb;
            end else begin
                n_hs  = w_rs;
                n_hfd = i_raw_byte[6:0];
                priority if (w_rs >= ST_ONE_DATA_MIN && w_rs < ST_ONE_DATA_END) begin
                    n_mb           = 1'b0;
                    w_job.bytes[0] = w_rs;
                    w_job.bytes[1] = i_raw_byte;
                    w_job.count    = 2'd2;
                    w_job.busy     = 1'b0;
                end else if (w_rs < ST_SYSEX_START) begin
                    n_aw = 1'b1;
                end else begin
                    n_rs = ST_NONE;
                    if (w_rs == ST_SONG_POS) begin
                        n_aw = 1'b1;
                    end else begin
                        n_mb           = 1'b0;
                        w_job.bytes[0] = w_rs;
                        w_job.bytes[1] = i_raw_byte;
                        w_job.count    = 2'd2;
                        w_job.busy     = 1'b0;
                    end
                end
            end
        end
    end

    assign o_job_push = i_accept && w_in_range && (w_job.count != 2'd0);
    assign o_job      = w_job;

    // Update the addressed port on every accepted item with a valid port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SOURCES; k++) begin
                r_rs[k]  <= '0;
                r_hs[k]  <= '0;
                r_hfd[k] <= '0;
                r_aw[k]  <= 1'b0;
                r_mb[k]  <= 1'b0;
            end
        end else if (i_accept && w_in_range) begin
            r_rs[w_idx]  <= n_rs;
            r_hs[w_idx]  <= n_hs;
            r_hfd[w_idx] <= n_hfd;
            r_aw[w_idx]  <= n_aw;
            r_mb[w_idx]  <= n_mb;
        end
    end

endmodule

// ----- rtl/core/mrse_queue.sv -----
module mrse_queue
    import mrse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_job     = r_entry[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/mrse_back.sv -----
module mrse_back
    import mrse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_message_byte,
    output logic       o_last_of_run,
    output logic       o_source_busy
);

    logic [1:0] r_sel;
    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_busy;
    logic       w_load;
    logic       w_last;
    logic [1:0] n_sel;

    // Step through the bytes of the head job, one per cycle while the output is free or popped.
    always_comb begin
        w_load    = i_job_valid && (!r_out_valid || i_pop);
        w_last    = (r_sel == (i_job.count - 2'd1));
        o_job_pop = w_load && w_last;
        n_sel     = r_sel;
        if (w_load) begin
            n_sel = w_last ? 2'd0 : r_sel + 2'd1;
        end
    end

    // Byte position and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_sel <= n_sel;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_job.bytes[r_sel];
            r_last <= w_last;
            r_busy <= i_job.busy;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_message_byte = r_byte;
    assign o_last_of_run  = r_last;
    assign o_source_busy  = r_busy;

endmodule

// ----- rtl/core/midi_running_status_expander_top.sv -----
// Channel  | Handshake           | Fields
// ---------+---------------------+------------------------------------------------
// input    | push / full         | i_source_port[1:0], i_raw_byte[7:0]
// result   | pop / empty         | o_message_byte[7:0], o_last_of_run, o_source_busy
//
// An item is classified and its per-port state updated in the cycle it is accepted.
// Its zero to three result bytes leave one per cycle from the output register while
// pop is held, serialized by the back end. Input is taken every cycle until the
// two-entry job queue fills; pop stalls the back end, and through it the input.
// Reset clears all per-port state and the queue.
module midi_running_status_expander_top
    import mrse_pkg::*;
#(
    parameter int NUM_SOURCES = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_source_port,
    input  logic [7:0] i_raw_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_message_byte,
    output logic       o_last_of_run,
    output logic       o_source_busy
);

    logic w_accept;
    logic w_job_push;
    t_job w_front_job;
    logic w_q_valid;
    t_job w_q_job;
    logic w_q_pop;

    assign w_accept = push && !full;

    // Front end: per-port state and classification.
    mrse_front #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_source_port (i_source_port),
        .i_raw_byte    (i_raw_byte),
        .o_job_push    (w_job_push),
        .o_job         (w_front_job)
    );

    // Job queue between the two halves.
    mrse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_front_job),
        .o_full  (full),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .i_pop   (w_q_pop)
    );

    // Back end: byte serializer and output register.
    mrse_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_q_valid),
        .i_job          (w_q_job),
        .o_job_pop      (w_q_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_message_byte (o_message_byte),
        .o_last_of_run  (o_last_of_run),
        .o_source_busy  (o_source_busy)
    );

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import mrse_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int NUM_PORTS      = 3;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 12;
    localparam int TIMEOUT_CYCLES = 200000;

    // MIDI codes used by the predictor and the stimulus beside the package ones.
    localparam logic [7:0] STATUS_MIN        = 8'h80;
    localparam logic [7:0] NOTE_ON           = 8'h90;
    localparam logic [7:0] PROGRAM_CHANGE    = 8'hC0;
    localparam logic [7:0] PITCH_BEND        = 8'hE0;
    localparam logic [7:0] MTC_QUARTER_FRAME = 8'hF1;
    localparam logic [7:0] SONG_SELECT       = 8'hF3;
    localparam logic [7:0] ACTIVE_SENSING    = 8'hFE;
    localparam logic [7:0] SYSTEM_RESET      = 8'hFF;

    localparam logic [1:0] PORT_A       = 2'd0;
    localparam logic [1:0] PORT_B       = 2'd1;
    localparam logic [1:0] PORT_HOST    = 2'd2;
    localparam logic [1:0] PORT_INVALID = 2'd3;

    typedef struct packed {
        logic [1:0] port;
        logic [7:0] raw;
    } t_midi_in;

    typedef struct packed {
        logic [7:0] msg;
        logic       last;
        logic       busy;
    } t_midi_out;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       push          = 1'b0;
    logic       pop           = 1'b0;
    logic [1:0] i_source_port = '0;
    logic [7:0] i_raw_byte    = '0;
    logic       full;
    logic       empty;
    logic [7:0] o_message_byte;
    logic       o_last_of_run;
    logic       o_source_busy;

    t_midi_in  midi_in_queue[$];
    t_midi_out expanded_bytes_due[$];

    int fail_count      = 0;
    int queued_count    = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int holdoff_left    = 0;
    bit holdoff_request = 1'b0;
    bit offer_taken     = 1'b0;

    // Per-port expander state kept by the predictor.
    logic [7:0] run_status  [NUM_PORTS];
    logic [7:0] held_status [NUM_PORTS];
    logic [6:0] held_data   [NUM_PORTS];
    logic       awaiting    [NUM_PORTS];
    logic       sysex_busy  [NUM_PORTS];

    midi_running_status_expander_top #(
        .NUM_SOURCES(NUM_PORTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_source_port (i_source_port),
        .i_raw_byte    (i_raw_byte),
        .empty         (empty),
        .pop           (pop),
        .o_message_byte(o_message_byte),
        .o_last_of_run (o_last_of_run),
        .o_source_busy (o_source_busy)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // Works out the bytes one accepted item expands into and updates the port state.
    function automatic void expand_midi_byte(input logic [1:0] port, input logic [7:0] raw);
        logic [7:0] out_bytes[3];
        logic [7:0] st;
        logic       busy;
        int         n;
        n    = 0;
        busy = 1'b0;
        if (port >= NUM_PORTS) begin
            return;
        end
        if (raw >= STATUS_MIN) begin
            if (raw >= ST_REALTIME_MIN) begin
                // Real-time bytes slip through without touching the port state.
                out_bytes[0] = raw;
                n            = 1;
                busy         = sysex_busy[port];
            end else begin
                awaiting[port]   = 1'b0;
                run_status[port] = raw;
                if (raw == ST_SYSEX_START) begin
                    sysex_busy[port] = 1'b1;
                    out_bytes[0]     = raw;
                    n                = 1;
                    busy             = 1'b1;
                end else if (raw == ST_TUNE_REQUEST || raw == ST_SYSEX_END) begin
                    run_status[port] = ST_NONE;
                    sysex_busy[port] = 1'b0;
                    out_bytes[0]     = raw;
                    n                = 1;
                end else if (raw == ST_UNDEF_F4 || raw == ST_UNDEF_F5) begin
                    run_status[port] = ST_NONE;
                end
            end
        end else if (awaiting[port]) begin
            // Second data byte completes a held message.
            awaiting[port]   = 1'b0;
            sysex_busy[port] = 1'b0;
            out_bytes[0]     = held_status[port];
            out_bytes[1]     = {1'b0, held_data[port]};
            out_bytes[2]     = raw;
            n                = 3;
        end else begin
            st = run_status[port];
            if (st == ST_SYSEX_START) begin
                out_bytes[0] = raw;
                n            = 1;
                busy         = sysex_busy[port];
            end else if (st != ST_NONE) begin
                held_status[port] = st;
                held_data[port]   = raw[6:0];
                if (st >= ST_ONE_DATA_MIN && st < ST_ONE_DATA_END) begin
                    sysex_busy[port] = 1'b0;
                    out_bytes[0]     = st;
                    out_bytes[1]     = raw;
                    n                = 2;
                end else if (st < ST_SYSEX_START) begin
                    awaiting[port] = 1'b1;
                end else begin
                    // System common messages never keep running status.
                    run_status[port] = ST_NONE;
                    if (st == ST_SONG_POS) begin
                        awaiting[port] = 1'b1;
                    end else begin
                        sysex_busy[port] = 1'b0;
                        out_bytes[0]     = st;
                        out_bytes[1]     = raw;
                        n                = 2;
                    end
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            expanded_bytes_due.push_back('{out_bytes[k], k == n - 1, busy});
        end
    endfunction

    // Take note of accepted items and predict their results.
    always @(posedge i_clk) begin
        offer_taken = i_rst_n && push && !full;
        if (offer_taken) begin
            expand_midi_byte(i_source_port, i_raw_byte);
            void'(midi_in_queue.pop_front());
        end
    end

    // Offer the next pending item, holding the current one until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || offer_taken) begin
            if (midi_in_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                push          <= 1'b1;
                i_source_port <= midi_in_queue[0].port;
                i_raw_byte    <= midi_in_queue[0].raw;
            end else begin
                push          <= 1'b0;
                i_source_port <= 2'($urandom_range(3));
                i_raw_byte    <= 8'($urandom_range(255));
            end
        end
    end

    // Drive pop with random stalls, or hold it off for a long stretch on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (holdoff_left > 0) begin
            pop <= 1'b0;
            holdoff_left = holdoff_left - 1;
        end else if (holdoff_request) begin
            pop <= 1'b0;
            holdoff_left    = HOLDOFF_CYCLES;
            holdoff_request = 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every popped result with the oldest predicted one.
    always @(posedge i_clk) begin
        t_midi_out exp_out;
        if (i_rst_n && pop && !empty) begin
            if (expanded_bytes_due.size() == 0) begin
                $error("unexpected result: message_byte %02h", o_message_byte);
                fail_count++;
            end else begin
                exp_out = expanded_bytes_due.pop_front();
                if (o_message_byte !== exp_out.msg) begin
                    $error("message_byte: expected %02h, actual %02h",
                           exp_out.msg, o_message_byte);
                    fail_count++;
                end
                if (o_last_of_run !== exp_out.last) begin
                    $error("last_of_run: expected %0b, actual %0b", exp_out.last, o_last_of_run);
                    fail_count++;
                end
                if (o_source_busy !== exp_out.busy) begin
                    $error("source_busy: expected %0b, actual %0b", exp_out.busy, o_source_busy);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_raw(input logic [1:0] port, input logic [7:0] raw);
        midi_in_queue.push_back('{port, raw});
        if (port < NUM_PORTS) begin
            queued_count++;
        end
    endtask

    // A data byte, now and then preceded by a real-time byte cutting into the message.
    task automatic queue_data(input logic [1:0] port, input logic [7:0] raw);
        if ($urandom_range(9) == 0) begin
            queue_raw(port, 8'(ST_REALTIME_MIN + $urandom_range(7)));
        end
        queue_raw(port, raw);
    endtask

    // One message sequence with random content on a random port; most are well-formed.
    task automatic queue_midi_message();
        logic [1:0] port;
        logic [7:0] status;
        int         n_data;
        port = 2'($urandom_range(NUM_PORTS - 1));
        case ($urandom_range(4))
            0, 1: begin
                // Channel message followed by a few running-status repeats.
                status = 8'(STATUS_MIN + $urandom_range(ST_SYSEX_START - STATUS_MIN - 1));
                n_data = (status >= ST_ONE_DATA_MIN && status < ST_ONE_DATA_END) ? 1 : 2;
                queue_raw(port, status);
                repeat ($urandom_range(1, 4)) begin
                    repeat (n_data) begin
                        queue_data(port, 8'($urandom_range(127)));
                    end
                end
            end
            2: begin
                queue_raw(port, ST_SYSEX_START);
                repeat ($urandom_range(6)) begin
                    queue_data(port, 8'($urandom_range(127)));
                end
                queue_raw(port, ($urandom_range(3) == 0) ? ST_TUNE_REQUEST : ST_SYSEX_END);
            end
            3: begin
                case ($urandom_range(2))
                    0:       status = MTC_QUARTER_FRAME;
                    1:       status = SONG_SELECT;
                    default: status = ST_SONG_POS;
                endcase
                queue_raw(port, status);
                repeat ((status == ST_SONG_POS) ? 2 : 1) begin
                    queue_data(port, 8'($urandom_range(127)));
                end
            end
            default: begin
                queue_raw(port, $urandom_range(1) ? ST_UNDEF_F4 : ST_UNDEF_F5);
                queue_data(port, 8'($urandom_range(127)));
            end
        endcase
    endtask

    // Mostly well-formed sequences, the rest raw noise on any port value.
    task automatic queue_random_traffic(input int target);
        int start_count;
        start_count = queued_count;
        while (queued_count - start_count < target) begin
            if ($urandom_range(4) == 0) begin
                queue_raw(2'($urandom_range(3)), 8'($urandom_range(255)));
            end else begin
                queue_midi_message();
            end
        end
    endtask

    task automatic wait_for_drain();
        while (midi_in_queue.size() != 0 || expanded_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        for (int p = 0; p < NUM_PORTS; p++) begin
            run_status[p]  = ST_NONE;
            held_status[p] = ST_NONE;
            held_data[p]   = '0;
            awaiting[p]    = 1'b0;
            sysex_busy[p]  = 1'b0;
        end
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases, no idling.
        queue_raw(PORT_INVALID, 8'h45);
        queue_raw(PORT_A, 8'h00);
        queue_raw(PORT_A, SYSTEM_RESET);
        queue_raw(PORT_A, NOTE_ON);
        queue_raw(PORT_A, 8'h3C);
        queue_raw(PORT_A, ST_REALTIME_MIN);
        queue_raw(PORT_A, 8'h7F);
        queue_raw(PORT_A, 8'h40);
        queue_raw(PORT_A, 8'h00);
        queue_raw(PORT_B, PROGRAM_CHANGE | 8'h05);
        queue_raw(PORT_B, 8'h7F);
        queue_raw(PORT_HOST, ST_SYSEX_START);
        queue_raw(PORT_HOST, 8'h12);
        queue_raw(PORT_HOST, ACTIVE_SENSING);
        queue_raw(PORT_HOST, ST_SYSEX_END);
        queue_raw(PORT_HOST, ST_SONG_POS);
        queue_raw(PORT_HOST, 8'h01);
        queue_raw(PORT_HOST, 8'h7F);
        queue_raw(PORT_HOST, 8'h05);
        queue_raw(PORT_B, MTC_QUARTER_FRAME);
        queue_raw(PORT_B, 8'h55);
        queue_raw(PORT_A, ST_UNDEF_F4);
        queue_raw(PORT_A, 8'h22);
        queue_raw(PORT_A, ST_TUNE_REQUEST);
        queue_raw(PORT_B, SONG_SELECT);
        queue_raw(PORT_B, 8'h01);
        queue_raw(PORT_B, ST_UNDEF_F5);
        queue_raw(PORT_A, PITCH_BEND | 8'h0F);
        queue_raw(PORT_INVALID, ST_SYSEX_START);
        wait_for_drain();

        // Back-pressure: the receiver holds off while the sender keeps offering.
        queue_random_traffic(30);
        holdoff_request = 1'b1;
        wait_for_drain();

        // Random traffic under each idling mix.
        queue_random_traffic(45);
        wait_for_drain();
        send_idle_pct = 66;
        queue_random_traffic(45);
        wait_for_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        queue_random_traffic(45);
        wait_for_drain();
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        queue_random_traffic(45);
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expanded_bytes_due.size() != 0) begin
            $error("%0d expected results never arrived", expanded_bytes_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS midi_running_status_expander_top");
        end else begin
            $display("FAIL midi_running_status_expander_top");
        end
        $finish;
    end

    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("FAIL midi_running_status_expander_top");
        $finish;
    end

endmodule
